@@ sv/key_debounce_toggle_long_press_unit_assert.svh @@
// assertion macros for the key debounce unit
// used by the top level only; expands to nothing under SYNTHESIS
`ifndef KEY_DEBOUNCE_TOGGLE_LONG_PRESS_UNIT_ASSERT_SVH
`define KEY_DEBOUNCE_TOGGLE_LONG_PRESS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// condition that must hold at every clock edge out of reset
`define KDT_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("kdt check failed");
// implication checked at every clock edge out of reset
`define KDT_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kdt check failed");
`else
`define KDT_ASSERT_ALWAYS(label, cond)
`define KDT_ASSERT_IMPLY(label, ante, cons)
`endif

`endif

@@ sv/kdt_pkg.sv @@
// shared types and constants for the key debounce unit
// no dependencies
`timescale 1ns / 1ps

package kdt_pkg;

	// configuration register indexes
	localparam int unsigned CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_SAMPLES = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_ON      = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_ACTIVE_LEVEL     = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_LONG_PRESS_MS    = 2'd3;
	localparam int unsigned CfgDataW = 32;

	// register reset values
	localparam logic [15:0] RST_DEBOUNCE_SAMPLES = 16'd20;
	localparam logic        RST_DEBOUNCE_ON      = 1'b1;
	localparam logic        RST_ACTIVE_LEVEL     = 1'b0;
	localparam logic [31:0] RST_LONG_PRESS_MS    = 32'd1000;

	// press event codes
	localparam logic [1:0] EV_IDLE       = 2'd0;
	localparam logic [1:0] EV_SHORT      = 2'd1;
	localparam logic [1:0] EV_LONG_READY = 2'd2;
	localparam logic [1:0] EV_LONG_HOLD  = 2'd3;

	// queue between front and back
	localparam int unsigned QueueDepth = 2;
	localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

	typedef struct packed {
		logic [15:0] debounce_samples;
		logic        debounce_on;
		logic        active_level;
		logic [31:0] long_press_ms;
	} kdt_cfg_t;

	// classified sample handed from front to back
	typedef struct packed {
		logic        level;
		logic        toggle;
		logic [31:0] now_ms;
	} kdt_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} kdt_q_status_t;

endpackage

@@ sv/kdt_in_if.sv @@
// input channel: raw key sample and timestamp with valid/ready
// no dependencies
`timescale 1ns / 1ps

interface kdt_in_if;
	logic        valid;
	logic        ready;
	logic        raw_level;
	logic [31:0] now_ms;

	modport source (output valid, output raw_level, output now_ms, input ready);
	modport sink (input valid, input raw_level, input now_ms, output ready);
endinterface

@@ sv/kdt_out_if.sv @@
// output channel: level, toggle latch and press event with valid/ready
// no dependencies
`timescale 1ns / 1ps

interface kdt_out_if;
	logic       valid;
	logic       ready;
	logic       stable_out;
	logic       toggle_out;
	logic [1:0] press_event;

	modport source (output valid, output stable_out, output toggle_out,
		output press_event, input ready);
	modport sink (input valid, input stable_out, input toggle_out,
		input press_event, output ready);
endinterface

@@ sv/key_debounce_toggle_long_press_unit.sv @@
// Key debounce, toggle latch and long-press detector.
// sample channel: raw key level and a millisecond timestamp, one per transaction.
// result channel: one transaction per sample with the level in use, the toggle
// latch and the press event (idle, short, long ready, long hold).
// Configuration: write cfg_wr_en with cfg_index and cfg_wdata, only while idle.
// The front end debounces and toggles in the accept cycle; a two-entry queue
// feeds the back end, which times presses and loads the output register.
// An accepted sample is written to a queue slot and then loaded into the output
// register, where its result becomes valid; a stall can hold it in the queue.
// Throughput: one sample per cycle while result.ready stays high, set by the front
// and back stages; the press timing path is one 32-bit subtract and compare.
// Reset clears all key state and loads the register reset values.
// When the receiver stalls, the result holds in the output register, the back
// end stops draining, and sample.ready falls once the queue is full.
// depends on kdt_pkg, kdt_in_if, kdt_out_if, kdt_front, kdt_queue, kdt_back
`timescale 1ns / 1ps
`include "key_debounce_toggle_long_press_unit_assert.svh"

module key_debounce_toggle_long_press_unit import kdt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	kdt_in_if.sink              sample,
	kdt_out_if.source           result,
	input  logic                cfg_wr_en,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata
);

	kdt_cfg_t      cfg_q;
	kdt_q_status_t q_stat;
	kdt_entry_t    push_entry;
	kdt_entry_t    head;
	logic          push;
	logic          pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_samples <= RST_DEBOUNCE_SAMPLES;
			cfg_q.debounce_on      <= RST_DEBOUNCE_ON;
			cfg_q.active_level     <= RST_ACTIVE_LEVEL;
			cfg_q.long_press_ms    <= RST_LONG_PRESS_MS;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DEBOUNCE_SAMPLES: cfg_q.debounce_samples <= cfg_wdata[15:0];
				REG_DEBOUNCE_ON:      cfg_q.debounce_on      <= cfg_wdata[0];
				REG_ACTIVE_LEVEL:     cfg_q.active_level     <= cfg_wdata[0];
				REG_LONG_PRESS_MS:    cfg_q.long_press_ms    <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	kdt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.sample     (sample),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	kdt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	kdt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.result (result)
	);

	// checks
	`KDT_ASSERT_ALWAYS(a_q_full_empty, !(q_stat.full && q_stat.empty))
	`KDT_ASSERT_IMPLY(a_no_pop_empty, q_stat.empty, !pop)
	`KDT_ASSERT_IMPLY(a_no_push_full, q_stat.full, !push)
	`KDT_ASSERT_IMPLY(a_result_kept, $fell(result.valid), $past(result.ready))

endmodule

@@ sv/kdt_front.sv @@
// front end: accepts samples, debounces the level and runs the toggle latch
// depends on kdt_pkg and kdt_in_if
`timescale 1ns / 1ps

module kdt_front import kdt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  kdt_cfg_t      cfg,
	kdt_in_if.sink        sample,
	input  kdt_q_status_t q_stat,
	output logic          push,
	output kdt_entry_t    push_entry
);

	logic        stable_q;
	logic [15:0] mismatch_q;
	logic        prev_level_q;
	logic        toggle_q;

	logic        stable_d;
	logic [15:0] mismatch_d;
	logic [15:0] mismatch_inc;
	logic        level;
	logic        toggle_d;

	assign sample.ready = !q_stat.full;
	assign push         = sample.valid && !q_stat.full;

	// counter debounce, saturating at the counter maximum
	always_comb begin
		stable_d     = stable_q;
		mismatch_d   = mismatch_q;
		mismatch_inc = (mismatch_q == 16'hFFFF) ? mismatch_q : mismatch_q + 16'd1;
		if (cfg.debounce_on) begin
			if (sample.raw_level != stable_q) begin
				if (mismatch_inc >= cfg.debounce_samples) begin
					stable_d   = sample.raw_level;
					mismatch_d = '0;
				end else begin
					mismatch_d = mismatch_inc;
				end
			end else begin
				mismatch_d = '0;
			end
			level = stable_d;
		end else begin
			level = sample.raw_level;
		end
	end

	// rising edge of the level flips the latch
	assign toggle_d = (level && !prev_level_q) ? !toggle_q : toggle_q;

	assign push_entry.level  = level;
	assign push_entry.toggle = toggle_d;
	assign push_entry.now_ms = sample.now_ms;

	// state advances on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q     <= 1'b0;
			mismatch_q   <= '0;
			prev_level_q <= 1'b0;
			toggle_q     <= 1'b0;
		end else if (push) begin
			stable_q     <= stable_d;
			mismatch_q   <= mismatch_d;
			prev_level_q <= level;
			toggle_q     <= toggle_d;
		end
	end

endmodule

@@ sv/kdt_queue.sv @@
// short fifo of classified samples between front and back
// depends on kdt_pkg
`timescale 1ns / 1ps

module kdt_queue import kdt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  kdt_entry_t    push_entry,
	input  logic          pop,
	output kdt_entry_t    head,
	output kdt_q_status_t q_stat
);

	kdt_entry_t       slot_q [QueueDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;

	assign q_stat.full  = (count_q == QCntW'(QueueDepth));
	assign q_stat.empty = (count_q == '0);
	assign head         = slot_q[rd_ptr_q];

	function automatic logic [QPtrW-1:0] ptr_next(input logic [QPtrW-1:0] p);
		return (p == QPtrW'(QueueDepth - 1)) ? '0 : p + QPtrW'(1);
	endfunction

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCntW'(1);
			end
		end
	end

endmodule

@@ sv/kdt_back.sv @@
// back end: press timing and the output register
// depends on kdt_pkg and kdt_out_if
`timescale 1ns / 1ps

module kdt_back import kdt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  kdt_cfg_t      cfg,
	input  kdt_entry_t    head,
	input  kdt_q_status_t q_stat,
	output logic          pop,
	kdt_out_if.source     result
);

	logic        pressing_q;
	logic        long_fired_q;
	logic [31:0] start_q;

	logic        out_valid_q;
	logic        stable_q;
	logic        toggle_q;
	logic [1:0]  event_q;

	logic        active;
	logic [31:0] elapsed;
	logic [31:0] hold;
	logic        reached;
	logic [1:0]  event_d;

	// take the head when the output register is free or being drained
	assign pop = !q_stat.empty && (!out_valid_q || result.ready);

	// hold time with wrapping subtraction
	always_comb begin
		active  = (head.level == cfg.active_level);
		elapsed = head.now_ms - start_q;
		hold    = pressing_q ? elapsed : '0;
		reached = (hold >= cfg.long_press_ms);
		if (active) begin
			if (reached) begin
				event_d = (pressing_q && long_fired_q) ? EV_LONG_HOLD : EV_LONG_READY;
			end else begin
				event_d = EV_IDLE;
			end
		end else begin
			event_d = (pressing_q && !reached) ? EV_SHORT : EV_IDLE;
		end
	end

	// press state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressing_q   <= 1'b0;
			long_fired_q <= 1'b0;
			start_q      <= '0;
		end else if (pop) begin
			pressing_q   <= active;
			long_fired_q <= active && (reached || (pressing_q && long_fired_q));
			if (!active) begin
				start_q <= '0;
			end else if (!pressing_q) begin
				start_q <= head.now_ms;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			stable_q <= head.level;
			toggle_q <= head.toggle;
			event_q  <= event_d;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.stable_out  = stable_q;
	assign result.toggle_out  = toggle_q;
	assign result.press_event = event_q;

endmodule

@@ tb/key_debounce_toggle_long_press_unit_tb.sv @@
// self-checking testbench for key_debounce_toggle_long_press_unit
// directed table, long debounce run and random phases, checked against an in-bench predictor
// depends on kdt_pkg, kdt_in_if, kdt_out_if and the unit itself
`timescale 1ns / 1ps

module key_debounce_toggle_long_press_unit_tb;
	import kdt_pkg::*;

	// threshold used by the long debounce run
	localparam int unsigned LongRunThreshold = 100;

	// one result transaction as the unit reports it
	typedef struct packed {
		logic       stable;
		logic       toggle;
		logic [1:0] press;
	} key_result_t;

	typedef enum logic {ROW_CONFIG, ROW_SAMPLE} row_kind_t;

	// one line of the directed table
	typedef struct {
		row_kind_t   kind;
		kdt_cfg_t    cfg;
		logic        raw;
		logic [31:0] stamp;
		logic        typed;
		key_result_t want;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_wdata;

	kdt_in_if  sample_ch ();
	kdt_out_if result_ch ();

	key_debounce_toggle_long_press_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	// predictor copy of the register file and key state
	kdt_cfg_t    shadow_cfg;
	logic        key_stable;
	logic [15:0] key_miss_run;
	logic        key_prev_level;
	logic        key_toggle;
	logic [31:0] press_t0;
	logic        press_active;
	logic        long_reported;

	key_result_t pending_results[$];
	stim_row_t   directed_rows[$];

	int unsigned mismatches      = 0;
	int unsigned results_checked = 0;
	int unsigned samples_sent    = 0;
	int unsigned settings_used   = 0;
	int unsigned events_seen[4]  = '{0, 0, 0, 0};
	bit          no_idling       = 1'b0;
	bit          sender_calm     = 1'b0;
	bit          receiver_calm   = 1'b0;

	// expected result of one sample; advances the predictor state
	function automatic key_result_t predict_key_result(input logic raw,
			input logic [31:0] stamp);
		key_result_t r;
		logic        lvl;
		logic [31:0] held;
		r.press = EV_IDLE;
		// counter debounce, or the raw pin when bypassed
		if (!shadow_cfg.debounce_on) begin
			lvl = raw;
		end else begin
			if (raw != key_stable) begin
				if (key_miss_run != 16'hFFFF)
					key_miss_run = key_miss_run + 16'd1;
				if (key_miss_run >= shadow_cfg.debounce_samples) begin
					key_stable   = raw;
					key_miss_run = 16'd0;
				end
			end else begin
				key_miss_run = 16'd0;
			end
			lvl = key_stable;
		end
		// toggle latch on rising level
		if (lvl && !key_prev_level)
			key_toggle = ~key_toggle;
		key_prev_level = lvl;
		// press timing with wrapping hold time
		if (lvl == shadow_cfg.active_level) begin
			if (!press_active) begin
				press_active  = 1'b1;
				press_t0      = stamp;
				long_reported = 1'b0;
			end
			held = stamp - press_t0;
			if (held >= shadow_cfg.long_press_ms) begin
				if (!long_reported) begin
					r.press       = EV_LONG_READY;
					long_reported = 1'b1;
				end else begin
					r.press = EV_LONG_HOLD;
				end
			end
		end else begin
			held = stamp - press_t0;
			if (press_active && held < shadow_cfg.long_press_ms)
				r.press = EV_SHORT;
			press_active  = 1'b0;
			long_reported = 1'b0;
			press_t0      = 32'd0;
		end
		r.stable = lvl;
		r.toggle = key_toggle;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input kdt_cfg_t c);
		stim_row_t r;
		r.kind  = ROW_CONFIG;
		r.cfg   = c;
		r.raw   = 1'b0;
		r.stamp = 32'd0;
		r.typed = 1'b0;
		r.want  = '0;
		return r;
	endfunction

	function automatic stim_row_t sample_row(input logic raw, input logic [31:0] stamp);
		stim_row_t r;
		r.kind  = ROW_SAMPLE;
		r.cfg   = '0;
		r.raw   = raw;
		r.stamp = stamp;
		r.typed = 1'b0;
		r.want  = '0;
		return r;
	endfunction

	function automatic stim_row_t checked_row(input logic raw, input logic [31:0] stamp,
			input key_result_t want);
		stim_row_t r;
		r       = sample_row(raw, stamp);
		r.typed = 1'b1;
		r.want  = want;
		return r;
	endfunction

	// one sample transaction, with an optional gap before it
	task automatic send_sample(input logic raw, input logic [31:0] stamp,
			input logic typed, input key_result_t want);
		key_result_t predicted;
		if (!no_idling && !sender_calm && $urandom_range(0, 4) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		sample_ch.valid     <= 1'b1;
		sample_ch.raw_level <= raw;
		sample_ch.now_ms    <= stamp;
		do @(posedge clk); while (!sample_ch.ready);
		predicted = predict_key_result(raw, stamp);
		pending_results.push_back(typed ? want : predicted);
		samples_sent++;
	endtask

	// drain, then write all four registers back to back
	task automatic configure(input kdt_cfg_t c);
		sample_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_DEBOUNCE_SAMPLES;
		cfg_wdata <= {16'd0, c.debounce_samples};
		@(posedge clk);
		cfg_index <= REG_DEBOUNCE_ON;
		cfg_wdata <= {31'd0, c.debounce_on};
		@(posedge clk);
		cfg_index <= REG_ACTIVE_LEVEL;
		cfg_wdata <= {31'd0, c.active_level};
		@(posedge clk);
		cfg_index <= REG_LONG_PRESS_MS;
		cfg_wdata <= c.long_press_ms;
		@(posedge clk);
		cfg_wr_en  <= 1'b0;
		shadow_cfg  = c;
		settings_used++;
	endtask

	// result checker against the oldest pending expectation
	always @(posedge clk) begin : result_check
		key_result_t got;
		key_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = {result_ch.stable_out, result_ch.toggle_out, result_ch.press_event};
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result stable %0d toggle %0d event %0d",
					$time, got.stable, got.toggle, got.press);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				events_seen[got.press]++;
				if (got !== want) begin
					$display("%0t: mismatch expected stable %0d toggle %0d event %0d,",
						$time, want.stable, want.toggle, want.press);
					$display("    actual stable %0d toggle %0d event %0d",
						got.stable, got.toggle, got.press);
					mismatches++;
				end
			end
		end
	end

	// receiver with random stall bursts and calm stretches
	initial begin : result_receiver
		int unsigned cyc;
		cyc             = 0;
		result_ch.ready = 1'b1;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 64 == 0)
				receiver_calm = ($urandom_range(0, 2) == 0);
			if (!no_idling && !receiver_calm && $urandom_range(0, 5) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				result_ch.ready <= 1'b1;
			end
		end
	end

	// run limit
	initial begin
		#16_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		kdt_cfg_t    c;
		stim_row_t   row;
		logic        key_target;
		logic        limit_level;
		logic        raw;
		logic [31:0] clock_ms;
		int unsigned run_left;
		int unsigned span;
		int unsigned directed_count;

		arst_n              = 1'b0;
		cfg_wr_en           = 1'b0;
		cfg_index           = '0;
		cfg_wdata           = '0;
		sample_ch.valid     = 1'b0;
		sample_ch.raw_level = 1'b0;
		sample_ch.now_ms    = 32'd0;
		shadow_cfg          = '{RST_DEBOUNCE_SAMPLES, RST_DEBOUNCE_ON, RST_ACTIVE_LEVEL,
			RST_LONG_PRESS_MS};
		key_stable          = 1'b0;
		key_miss_run        = 16'd0;
		key_prev_level      = 1'b0;
		key_toggle          = 1'b0;
		press_t0            = 32'd0;
		press_active        = 1'b0;
		long_reported       = 1'b0;

		// reset values, press starting at time zero
		directed_rows.push_back(checked_row(1'b0, 32'd0, '{1'b0, 1'b0, EV_IDLE}));
		directed_rows.push_back(sample_row(1'b0, 32'd999));
		directed_rows.push_back(checked_row(1'b0, 32'd1000, '{1'b0, 1'b0, EV_LONG_READY}));
		directed_rows.push_back(checked_row(1'b0, 32'd1001, '{1'b0, 1'b0, EV_LONG_HOLD}));
		directed_rows.push_back(sample_row(1'b1, 32'd1002));
		// zero threshold, maximum long time reached across the timestamp wrap
		// cfg order: debounce_samples, debounce_on, active_level, long_press_ms
		directed_rows.push_back(cfg_row('{16'd0, 1'b1, 1'b1, 32'hFFFF_FFFF}));
		directed_rows.push_back(sample_row(1'b0, 32'd0));
		directed_rows.push_back(sample_row(1'b1, 32'd1));
		directed_rows.push_back(sample_row(1'b1, 32'hFFFF_FFFF));
		directed_rows.push_back(sample_row(1'b1, 32'd0));
		directed_rows.push_back(sample_row(1'b0, 32'd0));
		// zero long time: ready on the first pressed sample, no short on release
		directed_rows.push_back(cfg_row('{16'd1, 1'b1, 1'b1, 32'd0}));
		directed_rows.push_back(sample_row(1'b1, 32'h1234_5678));
		directed_rows.push_back(sample_row(1'b1, 32'h1234_5679));
		directed_rows.push_back(sample_row(1'b0, 32'h1234_567A));
		// active low press timed across the wrap, then a short press across it
		directed_rows.push_back(cfg_row('{16'd0, 1'b1, 1'b0, 32'd100}));
		directed_rows.push_back(sample_row(1'b0, 32'hFFFF_FFC0));
		directed_rows.push_back(sample_row(1'b0, 32'h0000_0023));
		directed_rows.push_back(sample_row(1'b0, 32'h0000_0024));
		directed_rows.push_back(sample_row(1'b1, 32'h0000_0030));
		directed_rows.push_back(sample_row(1'b0, 32'hFFFF_FFF0));
		directed_rows.push_back(sample_row(1'b1, 32'h0000_0010));
		// debounce bypassed, filter state left alone
		directed_rows.push_back(cfg_row('{16'hFFFF, 1'b0, 1'b1, 32'd5}));
		directed_rows.push_back(sample_row(1'b1, 32'd0));
		directed_rows.push_back(sample_row(1'b0, 32'd3));
		directed_rows.push_back(sample_row(1'b1, 32'd4));
		directed_rows.push_back(sample_row(1'b1, 32'd9));
		directed_rows.push_back(sample_row(1'b0, 32'd10));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_CONFIG)
				configure(row.cfg);
			else
				send_sample(row.raw, row.stamp, row.typed, row.want);
		end
		directed_count = samples_sent;

		// long threshold: the counter must climb all the way before the level moves
		configure('{16'(LongRunThreshold), 1'b1, 1'b0, 32'd1000});
		no_idling   = 1'b1;
		limit_level = ~key_stable;
		for (int n = 0; n < LongRunThreshold + 1; n++)
			send_sample(limit_level, 32'(n), 1'b0, '0);
		no_idling = 1'b0;

		// random phases, each behind a drained register update
		key_target = 1'b0;
		run_left   = 0;
		clock_ms   = $urandom;
		for (int phase = 0; phase < 8; phase++) begin
			if (phase == 7)
				no_idling = 1'b1;
			c.debounce_samples = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
				: 16'($urandom_range(0, 4));
			c.debounce_on      = ($urandom_range(0, 4) != 0);
			c.active_level     = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 9))
				0:       c.long_press_ms = 32'd0;
				1:       c.long_press_ms = 32'hFFFF_FFFF;
				2:       c.long_press_ms = $urandom;
				default: c.long_press_ms = 32'($urandom_range(1, 60));
			endcase
			configure(c);
			for (int n = 0; n < 85; n++) begin
				if (n % 25 == 0)
					sender_calm = ($urandom_range(0, 2) == 0);
				// key held in runs of random length, with bounce
				if (run_left == 0) begin
					key_target = ~key_target;
					span       = ((c.debounce_samples < 6) ? c.debounce_samples : 6) + 10;
					run_left   = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 60)
						: $urandom_range(1, span);
				end
				run_left--;
				raw = key_target ^ ($urandom_range(0, 11) == 0);
				if ($urandom_range(0, 39) == 0)
					clock_ms = $urandom;
				else
					clock_ms = clock_ms + $urandom_range(0, 8);
				send_sample(raw, clock_ms, 1'b0, '0);
			end
		end

		// drain and let the pipeline settle
		sample_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d samples (%0d directed, one %0d-threshold debounce run)",
			samples_sent, directed_count, LongRunThreshold);
		$display("over %0d register settings; checked %0d results: idle %0d, short %0d,",
			settings_used, results_checked, events_seen[0], events_seen[1]);
		$display("long ready %0d, long hold %0d", events_seen[2], events_seen[3]);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ key_debounce_toggle_long_press_unit.f @@
+incdir+sv
sv/kdt_pkg.sv
sv/kdt_in_if.sv
sv/kdt_out_if.sv
sv/kdt_front.sv
sv/kdt_queue.sv
sv/kdt_back.sv
sv/key_debounce_toggle_long_press_unit.sv
tb/key_debounce_toggle_long_press_unit_tb.sv
